>>> design/irrd_pkg.sv
// ----------------------------------------------------------------------------
// irrd_pkg: shared types and constants of the interrupt distributor
// Holds the result kinds, the configuration register indexes, the layout of
// one routing-table entry and the fixed sizes of the interrupt groups.
// ----------------------------------------------------------------------------
`default_nettype none

package irrd_pkg;

    // Interrupts per pending word, and the size of the spurious window.
    localparam int GROUP_BITS    = 32;
    localparam int SPURIOUS_SPAN = 8;
    localparam int NUM_CPUS      = 4;
    localparam int NUM_GROUPS    = 4;

    // Field widths of the stream items.
    localparam int IRQ_W    = 7;
    localparam int GROUP_W  = 2;
    localparam int POS_W    = 5;
    localparam int AFF_W    = 4;
    localparam int CPU_W    = 2;
    localparam int CORE_W   = 3;
    localparam int CNT_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 7;

    // Last-core value meaning that the interrupt has not been forwarded yet.
    localparam logic [CORE_W-1:0] CORE_NONE = 3'd7;

    typedef enum logic [1:0] {
        KIND_LOCAL    = 2'd0,
        KIND_IPI      = 2'd1,
        KIND_SPURIOUS = 2'd2,
        KIND_ROUTE    = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_CPUS   = 2'd0,
        CFG_CPU_COUNT     = 2'd1,
        CFG_SPURIOUS_BASE = 2'd2
    } cfg_index_t;

    typedef enum logic {
        FUNC_ROUTE   = 1'b0,
        FUNC_PENDING = 1'b1
    } func_t;

    // One routing-table entry.
    typedef struct packed {
        logic             local_only;
        logic [POS_W-1:0] position;
        logic [AFF_W-1:0] affinity;
    } route_t;

    localparam route_t ROUTE_RESET = '{local_only: 1'b1, position: '0, affinity: '0};

endpackage

`default_nettype wire

>>> design/irrd_ram.sv
// ----------------------------------------------------------------------------
// irrd_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; the read data is registered and holds
// its value while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module irrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/interrupt_round_robin_distributor_unit.sv
// ----------------------------------------------------------------------------
// interrupt_round_robin_distributor_unit: round-robin interrupt distributor
// Keeps a routing entry and a last-used core for every interrupt in two
// synchronous RAMs, and turns each pending word into one dispatch decision
// per set bit, lowest bit first.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                Payload
//  s_axis   in         s_axis_tvalid/tready     tuser: func; tdata: route write or
//                                               pending word (see port list)
//  m_axis   out        m_axis_tvalid/tready     tuser: kind; tdata: irq, core,
//                                               IPI position; tlast: final result
//  cfg      in         cfg_we (no wait)         cfg_index, cfg_data
//
// After reset a clearing pass writes the reset entry into every row of both
// tables; s_axis_tready stays low meanwhile. A route write is taken in one
// transfer and its result passes the decide stage and the output register.
// The single read port of the tables handles one set bit of a pending word
// per cycle while m_axis does not stall. Each bit passes a read stage and a
// decide stage that writes the chosen core back; a stall on m_axis holds the
// decide stage and stops further reads until the output register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_round_robin_distributor_unit #(
    parameter int NUM_IRQS = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata from bit 0: group[1:0], pending[33:2], irq_index[40:34],
    // route_local[41], route_position[46:42], route_affinity[50:47], zeros.
    input  wire logic [55:0] s_axis_tdata,
    // tuser: func (0 route write, 1 pending word).
    input  wire logic [0:0]  s_axis_tuser,

    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata from bit 0: irq_number[6:0], target_cpu[8:7],
    // ipi_position[13:9], zeros.
    output logic [15:0]      m_axis_tdata,
    // tuser: kind (0 local, 1 IPI, 2 spurious, 3 route written).
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast,

    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [irrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [irrd_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW    = $clog2(NUM_IRQS);
    localparam int WIDE  = 9;
    localparam int GBITS = irrd_pkg::GROUP_BITS;
    localparam int BW    = $clog2(GBITS);
    localparam int NCPU  = irrd_pkg::NUM_CPUS;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [irrd_pkg::AFF_W-1:0] active_cpus_reg;
    logic [irrd_pkg::CNT_W-1:0] cpu_count_reg;
    logic [irrd_pkg::IRQ_W-1:0] spurious_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_cpus_reg   <= 4'd15;
            cpu_count_reg     <= 3'd4;
            spurious_base_reg <= 7'd56;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                irrd_pkg::CFG_ACTIVE_CPUS:
                begin
                    active_cpus_reg <= cfg_data[irrd_pkg::AFF_W-1:0];
                end
                irrd_pkg::CFG_CPU_COUNT:
                begin
                    cpu_count_reg <= cfg_data[irrd_pkg::CNT_W-1:0];
                end
                irrd_pkg::CFG_SPURIOUS_BASE:
                begin
                    spurious_base_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input field unpacking.
    // ------------------------------------------------------------------
    logic [irrd_pkg::GROUP_W-1:0] in_group;
    logic [GBITS-1:0]             in_pending;
    logic [irrd_pkg::IRQ_W-1:0]   in_irq_index;
    irrd_pkg::route_t             in_route;
    logic [WIDE-1:0]              in_irq_wide;
    logic                         in_accept;
    logic                         in_is_route;

    assign in_group            = s_axis_tdata[1:0];
    assign in_pending          = s_axis_tdata[33:2];
    assign in_irq_index        = s_axis_tdata[40:34];
    assign in_route.local_only = s_axis_tdata[41];
    assign in_route.position   = s_axis_tdata[46:42];
    assign in_route.affinity   = s_axis_tdata[50:47];
    assign in_irq_wide         = {2'b00, in_irq_index};

    assign in_accept   = s_axis_tvalid && s_axis_tready;
    assign in_is_route = (s_axis_tuser[0] == irrd_pkg::FUNC_ROUTE);

    // ------------------------------------------------------------------
    // Clearing pass after reset.
    // ------------------------------------------------------------------
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(NUM_IRQS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Read stage: pick the lowest remaining pending bit and read its entry.
    // ------------------------------------------------------------------
    logic [GBITS-1:0]             bits_reg;
    logic [GBITS-1:0]             bits_next;
    logic [irrd_pkg::GROUP_W-1:0] group_reg;
    logic [GBITS-1:0]             low_onehot;
    logic [BW-1:0]                low_index;
    logic [irrd_pkg::IRQ_W-1:0]   issue_irq;
    logic [WIDE-1:0]              issue_irq_wide;
    logic                         issue_en;
    logic                         out_free;

    logic                         d_valid_reg;
    logic                         d_route_reg;
    logic                         d_last_reg;
    logic                         d_intab_reg;
    logic [irrd_pkg::IRQ_W-1:0]   d_irq_reg;
    logic [AW-1:0]                d_addr_reg;
    logic                         d_adv;

    assign low_onehot = bits_reg & (~bits_reg + 1'b1);

    always_comb
    begin
        low_index = '0;
        for (int i = 0; i < GBITS; i++)
        begin
            if (low_onehot[i])
            begin
                low_index = low_index | BW'(i);
            end
        end
    end

    assign issue_irq      = {group_reg, low_index};
    assign issue_irq_wide = {2'b00, issue_irq};

    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign d_adv    = d_valid_reg && out_free;
    assign issue_en = (bits_reg != '0) && (!d_valid_reg || out_free);

    // A new item is taken only once the previous word has fully left the
    // read and decide stages; the output register may still be waiting.
    assign s_axis_tready = !clr_active_reg && (bits_reg == '0) && !d_valid_reg;

    always_comb
    begin
        bits_next = bits_reg;
        if (in_accept && !in_is_route)
        begin
            if ({1'b0, in_group} < 3'(irrd_pkg::NUM_GROUPS))
            begin
                bits_next = in_pending;
            end
            else
            begin
                bits_next = '0;
            end
        end
        else if (issue_en)
        begin
            bits_next = bits_reg & ~low_onehot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg    <= '0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            bits_reg <= bits_next;
            if ((in_accept && in_is_route) || issue_en)
            begin
                d_valid_reg <= 1'b1;
            end
            else if (d_adv)
            begin
                d_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            group_reg <= in_group;
        end
        if (in_accept && in_is_route)
        begin
            d_route_reg <= 1'b1;
            d_last_reg  <= 1'b1;
            d_irq_reg   <= in_irq_index;
            d_intab_reg <= 1'b0;
            d_addr_reg  <= in_irq_wide[AW-1:0];
        end
        else if (issue_en)
        begin
            d_route_reg <= 1'b0;
            d_last_reg  <= ((bits_reg & ~low_onehot) == '0);
            d_irq_reg   <= issue_irq;
            d_intab_reg <= (issue_irq_wide < WIDE'(NUM_IRQS));
            d_addr_reg  <= issue_irq_wide[AW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Tables: routing entries and last-used cores.
    // ------------------------------------------------------------------
    logic                        route_we;
    logic [AW-1:0]               route_waddr;
    irrd_pkg::route_t            route_wdata;
    irrd_pkg::route_t            route_rdata;

    logic                        core_we;
    logic [AW-1:0]               core_waddr;
    logic [irrd_pkg::CORE_W-1:0] core_wdata;
    logic [irrd_pkg::CORE_W-1:0] core_rdata;
    logic                        core_update;
    logic [irrd_pkg::CPU_W-1:0]  pick;

    // Route writes only happen while both stages are empty, so they never
    // meet a read of the same entry.
    assign route_we    = clr_active_reg ||
                         (in_accept && in_is_route && (in_irq_wide < WIDE'(NUM_IRQS)));
    assign route_waddr = clr_active_reg ? clr_addr_reg : in_irq_wide[AW-1:0];
    assign route_wdata = clr_active_reg ? irrd_pkg::ROUTE_RESET : in_route;

    assign core_we    = clr_active_reg || (d_adv && core_update);
    assign core_waddr = clr_active_reg ? clr_addr_reg : d_addr_reg;
    assign core_wdata = clr_active_reg ? irrd_pkg::CORE_NONE
                                       : {{(irrd_pkg::CORE_W - irrd_pkg::CPU_W){1'b0}}, pick};

    irrd_ram #(
        .WIDTH ($bits(irrd_pkg::route_t)),
        .DEPTH (NUM_IRQS)
    ) u_route_ram (
        .clk   (clk),
        .we    (route_we),
        .waddr (route_waddr),
        .wdata (route_wdata),
        .re    (issue_en),
        .raddr (issue_irq_wide[AW-1:0]),
        .rdata (route_rdata)
    );

    irrd_ram #(
        .WIDTH (irrd_pkg::CORE_W),
        .DEPTH (NUM_IRQS)
    ) u_core_ram (
        .clk   (clk),
        .we    (core_we),
        .waddr (core_waddr),
        .wdata (core_wdata),
        .re    (issue_en),
        .raddr (issue_irq_wide[AW-1:0]),
        .rdata (core_rdata)
    );

    // ------------------------------------------------------------------
    // Decide stage. Distinct bits of one word are distinct interrupts, so a
    // write-back here never races the read issued in the same cycle.
    // ------------------------------------------------------------------
    logic [irrd_pkg::CNT_W-1:0]  bound;
    logic [NCPU-1:0]             bound_mask;
    logic [NCPU-1:0]             usable;
    logic [irrd_pkg::CPU_W-1:0]  pick_up;
    logic [irrd_pkg::CPU_W-1:0]  pick_low;
    logic                        have_up;
    logic                        spurious;
    logic [irrd_pkg::IRQ_W:0]    spur_top;
    irrd_pkg::kind_t             res_kind;
    logic [irrd_pkg::CPU_W-1:0]  res_target;
    logic [irrd_pkg::POS_W-1:0]  res_pos;

    assign bound = (cpu_count_reg > irrd_pkg::CNT_W'(NCPU)) ? irrd_pkg::CNT_W'(NCPU)
                                                            : cpu_count_reg;

    assign spur_top = {1'b0, spurious_base_reg} + (irrd_pkg::IRQ_W + 1)'(irrd_pkg::SPURIOUS_SPAN);
    assign spurious = ({1'b0, d_irq_reg} >= {1'b0, spurious_base_reg}) &&
                      ({1'b0, d_irq_reg} < spur_top);

    always_comb
    begin
        for (int c = 0; c < NCPU; c++)
        begin
            bound_mask[c] = (irrd_pkg::CNT_W'(c) < bound);
        end
        usable   = route_rdata.affinity & active_cpus_reg & bound_mask;
        pick_up  = '0;
        pick_low = '0;
        have_up  = 1'b0;
        // Walk downwards so that the lowest qualifying core wins.
        for (int c = NCPU - 1; c >= 0; c--)
        begin
            if (usable[c])
            begin
                pick_low = irrd_pkg::CPU_W'(c);
                if ((core_rdata == irrd_pkg::CORE_NONE) ||
                    (irrd_pkg::CORE_W'(c) > core_rdata))
                begin
                    pick_up = irrd_pkg::CPU_W'(c);
                    have_up = 1'b1;
                end
            end
        end
        pick = have_up ? pick_up : pick_low;
    end

    always_comb
    begin
        res_kind    = irrd_pkg::KIND_LOCAL;
        res_target  = '0;
        res_pos     = '0;
        core_update = 1'b0;
        if (d_route_reg)
        begin
            res_kind = irrd_pkg::KIND_ROUTE;
        end
        else if (spurious)
        begin
            res_kind = irrd_pkg::KIND_SPURIOUS;
        end
        else if (!d_intab_reg || route_rdata.local_only || (usable == '0))
        begin
            res_kind = irrd_pkg::KIND_LOCAL;
        end
        else
        begin
            core_update = 1'b1;
            // Core 0 is the local core and needs no IPI.
            if (pick != '0)
            begin
                res_kind   = irrd_pkg::KIND_IPI;
                res_target = pick;
                res_pos    = route_rdata.position;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic m_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (d_adv)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_adv)
        begin
            m_axis_tdata <= {2'b00, res_pos, res_target, d_irq_reg};
            m_axis_tuser <= res_kind;
            m_axis_tlast <= d_last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_route_reaches_decide: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_is_route |=> d_valid_reg && d_route_reg)
        else $error("route write did not reach the decide stage");

    a_pending_starts_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !in_is_route |=> !d_valid_reg)
        else $error("pending word accepted with the decide stage busy");

    a_ipi_not_local: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == irrd_pkg::KIND_IPI) |-> m_axis_tdata[8:7] != 2'd0)
        else $error("IPI result aimed at the local core");

    a_core_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        core_we && !clr_active_reg |-> d_valid_reg && !d_route_reg && d_intab_reg)
        else $error("last-core table written outside a dispatch");

endmodule

`default_nettype wire

>>> tb/irrd_dispatch_checker.sv
// ----------------------------------------------------------------------------
// irrd_dispatch_checker: result predictor and scoreboard for the distributor
// Watches the input stream and the configuration port and keeps its own copy
// of the routing table, the last-used cores and the registers. From these it
// works out the dispatch decisions that every accepted transfer causes, then
// compares each result transfer with the oldest decision still owed.
// ----------------------------------------------------------------------------
`default_nettype none

module irrd_dispatch_checker
    import irrd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    input  wire logic [55:0]          s_axis_tdata,
    input  wire logic [0:0]           s_axis_tuser,
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic [15:0]          m_axis_tdata,
    input  wire logic [1:0]           m_axis_tuser,
    input  wire logic                 m_axis_tlast,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output int                        mismatches,
    output int                        results_due
);

    localparam int TABLE_DEPTH = NUM_GROUPS * GROUP_BITS;

    typedef struct packed {
        kind_t            kind;
        logic [IRQ_W-1:0] irq;
        logic [CPU_W-1:0] cpu;
        logic [POS_W-1:0] pos;
        logic             last;
    } dispatch_t;

    route_t            route_table [TABLE_DEPTH];
    logic [CORE_W-1:0] core_used   [TABLE_DEPTH];
    logic [AFF_W-1:0]  online_mask;
    logic [CNT_W-1:0]  core_count;
    logic [IRQ_W-1:0]  spur_base;
    dispatch_t         owed_q [$];
    int                err_cnt;

    // Decides where one pending interrupt goes and advances its round robin.
    function automatic dispatch_t decide(input int irq);
        dispatch_t        d;
        int               bound;
        int               pick;
        logic [AFF_W-1:0] usable;
        d = '{kind: KIND_LOCAL, irq: IRQ_W'(irq), cpu: '0, pos: '0, last: 1'b0};
        if (irq >= int'(spur_base) && irq < int'(spur_base) + SPURIOUS_SPAN)
        begin
            d.kind = KIND_SPURIOUS;
            return d;
        end
        if (route_table[irq].local_only)
            return d;
        bound  = (int'(core_count) < NUM_CPUS) ? int'(core_count) : NUM_CPUS;
        usable = route_table[irq].affinity & online_mask & AFF_W'((1 << bound) - 1);
        if (usable == '0)
            return d;
        pick = -1;
        for (int c = 0; c < bound; c++)
            if (pick < 0 && usable[c] &&
                (core_used[irq] == CORE_NONE || c > int'(core_used[irq])))
                pick = c;
        for (int c = 0; c < bound; c++)
            if (pick < 0 && usable[c])
                pick = c;
        core_used[irq] = CORE_W'(pick);
        if (pick != 0)
        begin
            d.kind = KIND_IPI;
            d.cpu  = CPU_W'(pick);
            d.pos  = route_table[irq].position;
        end
        return d;
    endfunction

    task automatic report(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [1:0]  grp;
        logic [31:0] word;
        int          top_bit;
        dispatch_t   d;
        dispatch_t   got;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                route_table[i] = ROUTE_RESET;
                core_used[i]   = CORE_NONE;
            end
            online_mask = 4'd15;
            core_count  = 3'd4;
            spur_base   = 7'd56;
            owed_q.delete();
            err_cnt     = 0;
            mismatches  <= 0;
            results_due <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ACTIVE_CPUS:   online_mask = cfg_data[AFF_W-1:0];
                    CFG_CPU_COUNT:     core_count  = cfg_data[CNT_W-1:0];
                    CFG_SPURIOUS_BASE: spur_base   = cfg_data[IRQ_W-1:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                grp  = s_axis_tdata[1:0];
                word = s_axis_tdata[33:2];
                if (s_axis_tuser[0] == FUNC_ROUTE)
                begin
                    // The last-used core of the entry survives a rewrite.
                    route_table[s_axis_tdata[40:34]] = '{local_only: s_axis_tdata[41],
                                                         position: s_axis_tdata[46:42],
                                                         affinity: s_axis_tdata[50:47]};
                    owed_q.push_back('{kind: KIND_ROUTE, irq: s_axis_tdata[40:34],
                                       cpu: '0, pos: '0, last: 1'b1});
                end
                else if (int'(grp) < NUM_GROUPS)
                begin
                    top_bit = -1;
                    for (int b = 0; b < GROUP_BITS; b++)
                        if (word[b])
                            top_bit = b;
                    for (int b = 0; b < GROUP_BITS; b++)
                        if (word[b])
                        begin
                            d      = decide(int'(grp) * GROUP_BITS + b);
                            d.last = (b == top_bit);
                            owed_q.push_back(d);
                        end
                end
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{kind: kind_t'(m_axis_tuser), irq: m_axis_tdata[6:0],
                        cpu: m_axis_tdata[8:7], pos: m_axis_tdata[13:9],
                        last: m_axis_tlast};
                if (owed_q.size() == 0)
                    report($sformatf("unexpected result: kind %0d irq %0d cpu %0d pos %0d last %0b",
                                     got.kind, got.irq, got.cpu, got.pos, got.last));
                else
                begin
                    d = owed_q.pop_front();
                    if (got !== d)
                        report($sformatf({"result mismatch: expected kind %0d irq %0d cpu %0d ",
                                          "pos %0d last %0b, got kind %0d irq %0d cpu %0d ",
                                          "pos %0d last %0b"},
                                         d.kind, d.irq, d.cpu, d.pos, d.last,
                                         got.kind, got.irq, got.cpu, got.pos, got.last));
                end
            end

            mismatches  <= err_cnt;
            results_due <= owed_q.size();
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_interrupt_round_robin_distributor_unit.sv
// ----------------------------------------------------------------------------
// tb_interrupt_round_robin_distributor_unit: stimulus and verdict
// Drives route writes and pending words into the distributor, moves through a
// series of register settings between drained phases, and lets the result
// stream stall at random. All checking sits in irrd_dispatch_checker, which
// reports its failure count back here for the final verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_interrupt_round_robin_distributor_unit;
    import irrd_pkg::*;

    // Worst case per item is 32 results each behind a stall burst; the limit
    // leaves ample room for that, for the clearing pass after reset and for
    // the drain pauses.
    localparam int CYCLE_LIMIT    = 400000;
    // Longest time the block may still be busy on a word that owes nothing.
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASES         = 7;
    localparam int ITEMS_PER_PHASE = 27;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_axis_tready;
    logic [55:0]          s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_axis_tvalid;
    logic                 m_tready;
    logic [15:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int chk_errors;
    int chk_due;
    int cycles = 0;
    int gap_pct;        // chance of a gap before an input transfer
    int stall_pct;      // chance of a stall burst on the result stream
    int stall_left;

    interrupt_round_robin_distributor_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    irrd_dispatch_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (chk_errors),
        .results_due   (chk_due)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result-side back-pressure. A stall burst holds tready low and tready
    // always goes high again before the next burst, so stalls land on
    // every phase of a long word without starving the sink.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (!m_tready)
            m_tready <= 1'b1;
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
    end

    // Presents one input transfer and returns at the edge that accepts it.
    // Valid is left high so that back-to-back transfers need no extra edge.
    task automatic send_raw(input func_t fn, input logic [55:0] payload);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        s_tuser  <= fn;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_route(input logic [IRQ_W-1:0] irq, input logic loc,
                              input logic [POS_W-1:0] pos, input logic [AFF_W-1:0] aff);
        send_raw(FUNC_ROUTE, {5'd0, aff, pos, loc, irq, 32'd0, 2'd0});
    endtask

    task automatic send_pending(input logic [GROUP_W-1:0] grp, input logic [31:0] word);
        send_raw(FUNC_PENDING, {5'd0, 4'd0, 5'd0, 1'b0, 7'd0, word, grp});
    endtask

    // Waits until every owed result has been seen, then lets the block finish
    // any word that owes nothing before the registers are touched.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (chk_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers on consecutive edges.
    task automatic set_config(input logic [AFF_W-1:0] act, input logic [CNT_W-1:0] cnt,
                              input logic [IRQ_W-1:0] base);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACTIVE_CPUS;
        cfg_data  <= {3'd0, act};
        @(posedge clk);
        cfg_index <= CFG_CPU_COUNT;
        cfg_data  <= {4'd0, cnt};
        @(posedge clk);
        cfg_index <= CFG_SPURIOUS_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random traffic is aimed mostly at one byte of one group, so that the
    // pending words keep hitting entries that have been routed to real cores
    // and the round robin of each entry gets turned many times. The rest is
    // scattered writes, full random words and words that are all ones or empty.
    task automatic random_item(input logic [1:0] hot_grp, input int hot_byte);
        logic [1:0]  grp;
        logic [6:0]  irq;
        logic [31:0] word;
        int          mode;
        grp = ($urandom_range(0, 9) < 7) ? hot_grp : 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 40)
        begin
            if ($urandom_range(0, 4) != 0)
                irq = {grp, 5'(hot_byte * 8 + $urandom_range(0, 7))};
            else
                irq = 7'($urandom);
            send_route(irq, $urandom_range(0, 4) == 0, 5'($urandom), 4'($urandom));
        end
        else
        begin
            mode = $urandom_range(0, 9);
            if (mode < 6)
                word = $urandom & (32'hFF << (8 * hot_byte));
            else if (mode < 9)
                word = $urandom;
            else
                word = $urandom_range(0, 1) ? '1 : '0;
            send_pending(grp, word);
        end
    endtask

    initial
    begin
        logic [1:0] hot_grp;
        int         hot_byte;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= FUNC_ROUTE;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_ACTIVE_CPUS;
        cfg_data  <= '0;
        gap_pct    = 20;
        stall_pct <= 20;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, under the register values left by reset.
        // An empty word owes nothing; a full word of group 1 runs over the
        // spurious window while every other interrupt is still local-only.
        send_pending(2'd0, 32'h0000_0000);
        send_pending(2'd1, 32'hFFFF_FFFF);
        // Entries for a full round robin, an empty affinity, a local-only
        // entry, an entry pinned to core 0 and two entries in the top group.
        send_route(7'd5,   1'b0, 5'd31, 4'b1111);
        send_route(7'd6,   1'b0, 5'd0,  4'b0000);
        send_route(7'd7,   1'b1, 5'd17, 4'b1111);
        send_route(7'd0,   1'b0, 5'd9,  4'b0001);
        send_route(7'd127, 1'b0, 5'd21, 4'b1010);
        send_route(7'd96,  1'b0, 5'd3,  4'b1100);
        // Five passes walk interrupt 5 through every core and back to core 0.
        repeat (5) send_pending(2'd0, 32'h0000_00E1);
        repeat (3) send_pending(2'd3, 32'h8000_0001);
        send_route(7'd64, 1'b0, 5'd31, 4'b1111);
        repeat (2) send_pending(2'd2, 32'h0000_0001);

        // Random phases, each behind a drain and a fresh register setting.
        // The settings cover no online core, a core count of zero, a count
        // beyond the number of cores, and spurious windows at both ends.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0: set_config(4'd15, 3'd4, 7'd56);
                1: set_config(4'd0,  3'd4, 7'd120);
                2: set_config(4'd10, 3'd2, 7'd0);
                3: set_config(4'd15, 3'd7, 7'd127);
                4: set_config(4'd6,  3'd0, 7'd124);
                5: set_config(4'($urandom), 3'($urandom_range(1, 4)), 7'($urandom));
                default: set_config(4'd15, 3'd3, 7'd88);
            endcase
            // Phase 1 and the final phase run without any idling.
            case (ph)
                1, PHASES - 1:
                begin
                    gap_pct    = 0;
                    stall_pct <= 0;
                end
                2:
                begin
                    gap_pct    = 30;
                    stall_pct <= 40;
                end
                4:
                begin
                    gap_pct    = 40;
                    stall_pct <= 0;
                end
                default:
                begin
                    gap_pct    = 25;
                    stall_pct <= 25;
                end
            endcase
            hot_grp  = 2'($urandom_range(0, 3));
            hot_byte = $urandom_range(0, 3);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                random_item(hot_grp, hot_byte);
        end

        drain();
        if (chk_errors == 0 && chk_due == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
design/irrd_pkg.sv
design/irrd_ram.sv
design/interrupt_round_robin_distributor_unit.sv
tb/irrd_dispatch_checker.sv
tb/tb_interrupt_round_robin_distributor_unit.sv
